/* sv/apc_pkg.sv */
// Shared types and constants of the articulation point counter.
package apc_pkg;

	// Command codes of an input beat
	typedef enum logic [1:0] {
		FUNC_ADD_EDGE = 2'd0,
		FUNC_RUN      = 2'd1,
		FUNC_CLEAR    = 2'd2
	} func_t;

	// Register file layout
	localparam int CFG_AW = 3;
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic [5:0] VERTEX_COUNT_RESET = 6'd8;

	// Largest value a result field holds
	localparam logic [6:0] COUNT_MAX = 7'd63;

endpackage

/* sv/apc_if.sv */
// Handshake channels for command beats and result beats.
interface apc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [4:0] src_vertex;
	logic [4:0] dst_vertex;

	modport source (output valid, func, src_vertex, dst_vertex, input ready);
	modport sink (input valid, func, src_vertex, dst_vertex, output ready);
endinterface

interface apc_res_if;
	logic       valid;
	logic       ready;
	logic [5:0] component_count;
	logic [5:0] articulation_count;

	modport source (output valid, component_count, articulation_count, input ready);
	modport sink (input valid, component_count, articulation_count, output ready);
endinterface

/* sv/articulation_point_counter.sv */
// Top level of the articulation point counter.
// The adjacency matrix lives in a one-port-read, one-port-write memory, one row of
// MAX_VERTICES bits per source vertex; a row valid bit per entry makes reset and a
// clear beat empty the graph at once. An add-edge beat reads the row, then writes
// it back with the new bit. A run beat makes n+1 reachability sweeps
// (n = min(vertex_count, MAX_VERTICES)): the whole graph, then once with each
// vertex deleted. For every vertex it reaches, a sweep reads the memory row, then
// merges the row into the visited set; a closing step scores the sweep before the
// next one, and after the last sweep the result beat is offered.
// The block takes one command at a time; a pending result waits in an output
// register while the next command is taken.
module articulation_point_counter
	import apc_pkg::*;
#(
	parameter int MAX_VERTICES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	apc_cmd_if.sink           cmd,
	apc_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int MV = MAX_VERTICES;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EDGE   = 5'b00010,
		ST_PICK   = 5'b00100,
		ST_MERGE  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t            state_q;
	logic [5:0]        vertex_count_q;
	logic [MV-1:0]     adj_mem [MV];
	logic [MV-1:0]     row_rd_q;
	logic [MV-1:0]     row_vld_q;
	logic [AW-1:0]     src_q;
	logic [AW-1:0]     dst_q;
	logic [AW-1:0]     v_q;
	logic [MV-1:0]     visited_q;
	logic [MV-1:0]     pending_q;
	logic [NW-1:0]     cnt_q;
	logic [NW-1:0]     base_q;
	logic [NW-1:0]     cuts_q;
	logic [NW-1:0]     del_q;
	logic              base_phase_q;
	logic              res_vld_q;
	logic [5:0]        res_comp_q;
	logic [5:0]        res_cuts_q;

	logic [6:0]        vc_x;
	logic [NW-1:0]     n_use;
	logic [MV-1:0]     allowed;
	logic [MV-1:0]     cand;
	logic [MV-1:0]     pick_set;
	logic [MV-1:0]     pick_bit;
	logic [AW-1:0]     pick_idx;
	logic [MV-1:0]     row_data;
	logic [MV-1:0]     new_bits;
	logic [6:0]        src_x;
	logic [6:0]        dst_x;
	logic              edge_ok;
	logic              cmd_fire;
	logic              res_free;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [NW-1:0]     del_next;
	logic [6:0]        base_x;
	logic [6:0]        cuts_x;
	logic              cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {26'd0, vertex_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[5:0];
		end
	end

	// Vertices in use and the sweep's allowed set
	assign vc_x  = {1'b0, vertex_count_q};
	assign n_use = (vc_x >= 7'(MV)) ? NW'(MV) : vc_x[NW-1:0];

	always_comb begin
		for (int i = 0; i < MV; i++) begin
			allowed[i] = (NW'(i) < n_use) && !(!base_phase_q && del_q == NW'(i));
		end
	end

	// Pick the lowest pending vertex, else the lowest unvisited start
	assign cand     = allowed & ~visited_q;
	assign pick_set = (pending_q != '0) ? pending_q : cand;
	assign pick_bit = pick_set & (~pick_set + MV'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < MV; i++) begin
			if (pick_bit[i]) begin
				pick_idx = pick_idx | AW'(i);
			end
		end
	end

	// Merge the fetched row into the visited set
	assign row_data = row_vld_q[v_q] ? row_rd_q : '0;
	assign new_bits = row_data & allowed & ~visited_q;

	// Command decode
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign src_x     = {2'b00, cmd.src_vertex};
	assign dst_x     = {2'b00, cmd.dst_vertex};
	assign edge_ok   = (src_x < 7'(MV)) && (dst_x < 7'(MV));
	assign del_next  = base_phase_q ? '0 : del_q + NW'(1);

	// Adjacency memory access
	assign rd_en   = (cmd_fire && cmd.func == FUNC_ADD_EDGE && edge_ok) ||
		(state_q == ST_PICK && pick_set != '0);
	assign rd_addr = (state_q == ST_IDLE) ? src_x[AW-1:0] : pick_idx;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_rd_q <= adj_mem[rd_addr];
		end
		if (state_q == ST_EDGE) begin
			adj_mem[src_q] <= (row_vld_q[src_q] ? row_rd_q : '0) | (MV'(1) << dst_q);
		end
	end

	// Result beat
	assign res_free = !res_vld_q || res.ready;
	assign base_x   = 7'(base_q);
	assign cuts_x   = 7'(cuts_q);

	assign res.valid              = res_vld_q;
	assign res.component_count    = res_comp_q;
	assign res.articulation_count = res_cuts_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && res_free) begin
			res_comp_q <= (base_x > COUNT_MAX) ? COUNT_MAX[5:0] : base_x[5:0];
			res_cuts_q <= (cuts_x > COUNT_MAX) ? COUNT_MAX[5:0] : cuts_x[5:0];
		end
	end

	// Edge fields and merge address
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			src_q <= src_x[AW-1:0];
			dst_q <= dst_x[AW-1:0];
		end
		if (state_q == ST_PICK && pick_set != '0) begin
			v_q <= pick_idx;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_vld_q    <= '0;
			visited_q    <= '0;
			pending_q    <= '0;
			cnt_q        <= '0;
			base_q       <= '0;
			cuts_q       <= '0;
			del_q        <= '0;
			base_phase_q <= 1'b1;
			res_vld_q    <= 1'b0;
		end else begin
			// Raise the result at the end of a run, drop it once taken
			if (state_q == ST_FINISH && res_free) begin
				res_vld_q <= 1'b1;
			end else if (res_vld_q && res.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.func)
							FUNC_ADD_EDGE: begin
								if (edge_ok) begin
									state_q <= ST_EDGE;
								end
							end
							FUNC_CLEAR: begin
								row_vld_q <= '0;
							end
							FUNC_RUN: begin
								base_phase_q <= 1'b1;
								del_q        <= '0;
								cuts_q       <= '0;
								cnt_q        <= '0;
								visited_q    <= '0;
								pending_q    <= '0;
								state_q      <= ST_PICK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EDGE: begin
					row_vld_q[src_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_PICK: begin
					if (pick_set != '0) begin
						// Open a component when no vertex is pending
						if (pending_q == '0) begin
							cnt_q <= cnt_q + NW'(1);
						end
						visited_q <= visited_q | pick_bit;
						pending_q <= pending_q & ~pick_bit;
						state_q   <= ST_MERGE;
					end else begin
						// Close the sweep and score it
						if (base_phase_q) begin
							base_q <= cnt_q;
						end else if (cnt_q > base_q) begin
							cuts_q <= cuts_q + NW'(1);
						end
						base_phase_q <= 1'b0;
						del_q        <= del_next;
						cnt_q        <= '0;
						visited_q    <= '0;
						pending_q    <= '0;
						if (del_next >= n_use) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_MERGE: begin
					visited_q <= visited_q | new_bits;
					pending_q <= pending_q | new_bits;
					state_q   <= ST_PICK;
				end
				ST_FINISH: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/testbench.sv */
// Testbench of the articulation point counter: random graphs, predicted counts, APB setup.
module testbench
	import apc_pkg::*;
();

	localparam int NODES = 32;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [CFG_AW-1:0] VERTEX_COUNT_ADDR = CFG_AW'(4 * int'(REG_VERTEX_COUNT));
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 160;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] src;
		logic [4:0] dst;
	} command_t;

	typedef struct packed {
		logic [5:0] components;
		logic [5:0] cuts;
	} tally_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	apc_cmd_if cmd_bus ();
	apc_res_if res_bus ();

	articulation_point_counter #(.MAX_VERTICES(NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.res(res_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Graph copy kept by the predictor
	logic [NODES-1:0] adjacency [NODES];
	logic [5:0] vertex_limit = VERTEX_COUNT_RESET;

	command_t pending_cmds [$];
	tally_t expected_tallies [$];
	int sent_total = 0;
	int taken_total = 0;
	int items_made = 0;
	int failures = 0;
	int send_idle_max = 0;
	int recv_idle_max = 0;
	logic hold_output = 1'b0;
	int send_wait;
	int recv_wait;
	command_t next_cmd;
	tally_t got_tally;
	tally_t want_tally;
	tally_t made_tally;
	int sweep_n;
	int base_comps;
	int cut_total;

	// Count components of the index-order sweep with the excluded vertices deleted
	function automatic int count_components(int n, logic [NODES-1:0] excluded);
		logic [NODES-1:0] allowed;
		logic [NODES-1:0] seen;
		logic [NODES-1:0] reach;
		logic [NODES-1:0] grown;
		int comps;
		allowed = (n >= NODES) ? '1 : ((NODES'(1) << n) - NODES'(1));
		allowed &= ~excluded;
		seen = '0;
		comps = 0;
		for (int s = 0; s < n; s++) begin
			if (allowed[s] && !seen[s]) begin
				comps++;
				reach = NODES'(1) << s;
				forever begin
					grown = reach;
					for (int v = 0; v < n; v++)
						if (reach[v])
							grown |= adjacency[v];
					grown = (grown & allowed & ~seen) | reach;
					if (grown == reach)
						break;
					reach = grown;
				end
				seen |= reach;
			end
		end
		return comps;
	endfunction

	function automatic logic [4:0] pick_vertex(int n);
		if ($urandom_range(0, 7) == 0 || n < 1)
			return 5'($urandom_range(0, NODES - 1));
		return 5'($urandom_range(0, n - 1));
	endfunction

	task automatic push_command(logic [1:0] func, logic [4:0] src, logic [4:0] dst);
		command_t c;
		c.func = func;
		c.src = src;
		c.dst = dst;
		pending_cmds.insert(pending_cmds.size(), c);
		sent_total++;
		if (func != FUNC_UNUSED)
			items_made++;
	endtask

	// Queue well-formed graph sequences with random content, plus some noise
	task automatic queue_sequences(int n, int quota);
		int target;
		int style;
		int a;
		int v;
		target = items_made + quota;
		while (items_made < target) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 4) != 0)
					push_command(FUNC_CLEAR, 5'($urandom), 5'($urandom));
				style = $urandom_range(0, 2);
				if (style == 0) begin
					// random tree, edges in random directions
					for (v = 1; v < n; v++) begin
						a = $urandom_range(0, v - 1);
						case ($urandom_range(0, 2))
							0: push_command(FUNC_ADD_EDGE, 5'(a), 5'(v));
							1: push_command(FUNC_ADD_EDGE, 5'(v), 5'(a));
							default: begin
								push_command(FUNC_ADD_EDGE, 5'(a), 5'(v));
								push_command(FUNC_ADD_EDGE, 5'(v), 5'(a));
							end
						endcase
					end
				end else if (style == 1) begin
					repeat ($urandom_range(0, 2 * n))
						push_command(FUNC_ADD_EDGE, pick_vertex(n), pick_vertex(n));
				end else begin
					// two-way path with a few chords
					for (v = 1; v < n; v++) begin
						push_command(FUNC_ADD_EDGE, 5'(v - 1), 5'(v));
						push_command(FUNC_ADD_EDGE, 5'(v), 5'(v - 1));
					end
					repeat ($urandom_range(0, 3))
						push_command(FUNC_ADD_EDGE, pick_vertex(n), pick_vertex(n));
				end
				push_command(FUNC_RUN, 5'($urandom), 5'($urandom));
				if ($urandom_range(0, 3) == 0) begin
					push_command(FUNC_ADD_EDGE, pick_vertex(n), pick_vertex(n));
					push_command(FUNC_RUN, 5'($urandom), 5'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 4))
					push_command(2'($urandom_range(0, 3)), 5'($urandom), 5'($urandom));
			end
		end
	endtask

	// Wait until every beat is taken and every result has come, then let the block settle
	task automatic wait_quiet();
		while (taken_total != sent_total)
			@(posedge clk);
		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the vertex count over APB, then read it back
	task automatic write_vertex_count(logic [5:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= VERTEX_COUNT_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		vertex_limit = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[5:0] != value) begin
			if (failures < 10)
				$display("vertex_count readback: exp %0d got %0d", value, prdata[5:0]);
			failures++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("FAIL");
		$finish;
	end

	// Command driver; predict each beat as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.func <= FUNC_ADD_EDGE;
			cmd_bus.src_vertex <= '0;
			cmd_bus.dst_vertex <= '0;
			send_wait = 0;
			adjacency = '{default: '0};
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				taken_total++;
				case (cmd_bus.func)
					FUNC_ADD_EDGE: adjacency[cmd_bus.src_vertex][cmd_bus.dst_vertex] = 1'b1;
					FUNC_CLEAR: adjacency = '{default: '0};
					FUNC_RUN: begin
						sweep_n = (int'(vertex_limit) > NODES) ? NODES : int'(vertex_limit);
						base_comps = count_components(sweep_n, '0);
						cut_total = 0;
						for (int d = 0; d < sweep_n; d++)
							if (count_components(sweep_n, NODES'(1) << d) > base_comps)
								cut_total++;
						made_tally.components = 6'(base_comps);
						made_tally.cuts = 6'(cut_total);
						expected_tallies.insert(expected_tallies.size(), made_tally);
					end
					default: ;
				endcase
			end
			// Advance to the next beat once the slot is free
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (send_wait != 0) begin
					send_wait--;
					cmd_bus.valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					next_cmd = pending_cmds.pop_front();
					cmd_bus.func <= next_cmd.func;
					cmd_bus.src_vertex <= next_cmd.src;
					cmd_bus.dst_vertex <= next_cmd.dst;
					cmd_bus.valid <= 1'b1;
					send_wait = $urandom_range(0, send_idle_max);
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				got_tally.components = res_bus.component_count;
				got_tally.cuts = res_bus.articulation_count;
				if (expected_tallies.size() == 0) begin
					if (failures < 10)
						$display("unexpected result: component_count %0d articulation_count %0d",
							got_tally.components, got_tally.cuts);
					failures++;
				end else begin
					want_tally = expected_tallies.pop_front();
					if (got_tally.components != want_tally.components ||
							got_tally.cuts != want_tally.cuts) begin
						if (failures < 10)
							$display("mismatch: component_count exp %0d got %0d, %s %0d got %0d",
								want_tally.components, got_tally.components,
								"articulation_count exp", want_tally.cuts, got_tally.cuts);
						failures++;
					end
				end
				recv_wait = $urandom_range(0, recv_idle_max);
			end
			// Hold ready low through a stall or a long hold-off
			if (hold_output) begin
				res_bus.ready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty graph, a path, duplicate, out-of-range endpoints, unused code, clear
		push_command(FUNC_RUN, 5'd0, 5'd0);
		push_command(FUNC_ADD_EDGE, 5'd0, 5'd1);
		push_command(FUNC_ADD_EDGE, 5'd1, 5'd2);
		push_command(FUNC_ADD_EDGE, 5'd2, 5'd3);
		push_command(FUNC_ADD_EDGE, 5'd0, 5'd1);
		push_command(FUNC_RUN, 5'd31, 5'd31);
		push_command(FUNC_ADD_EDGE, 5'd31, 5'd31);
		push_command(FUNC_ADD_EDGE, 5'd7, 5'd31);
		push_command(FUNC_ADD_EDGE, 5'd31, 5'd0);
		push_command(FUNC_UNUSED, 5'd5, 5'd6);
		push_command(FUNC_RUN, 5'd0, 5'd0);
		push_command(FUNC_CLEAR, 5'd31, 5'd31);
		push_command(FUNC_RUN, 5'd0, 5'd0);
		push_command(FUNC_ADD_EDGE, 5'd7, 5'd0);
		push_command(FUNC_ADD_EDGE, 5'd0, 5'd0);
		wait_quiet();
		write_vertex_count(6'd1);
		push_command(FUNC_RUN, 5'd0, 5'd0);
		wait_quiet();
		write_vertex_count(6'd0);
		push_command(FUNC_RUN, 5'd0, 5'd0);
		wait_quiet();
		write_vertex_count(6'd63);
		push_command(FUNC_ADD_EDGE, 5'd31, 5'd30);
		push_command(FUNC_ADD_EDGE, 5'd30, 5'd7);
		push_command(FUNC_RUN, 5'd0, 5'd0);
		wait_quiet();
		write_vertex_count(6'd33);
		push_command(FUNC_ADD_EDGE, 5'd15, 5'd16);
		push_command(FUNC_RUN, 5'd0, 5'd0);
		wait_quiet();

		// Random phases over several vertex counts and idle patterns
		for (int p = 0; p < PHASES; p++) begin
			automatic int vc;
			if (p == 0)
				vc = NODES;
			else if (p == 6)
				vc = $urandom_range(17, NODES - 1);
			else
				vc = $urandom_range(1, 12);
			write_vertex_count(6'(vc));
			send_idle_max <= (p % 4 == 1 || p % 4 == 2) ? 10 : 0;
			recv_idle_max <= (p % 4 == 1 || p % 4 == 3) ? 10 : 0;
			if (p == 2) begin
				fork
					begin
						hold_output <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_output <= 1'b0;
					end
				join_none
			end
			queue_sequences(vc, PHASE_ITEMS / 2);
			// Pause the sender until every result is back
			if (p % 2 == 1)
				wait_quiet();
			queue_sequences(vc, PHASE_ITEMS / 2);
			wait_quiet();
		end

		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
